// ===== rtl/bct_pkg.sv =====
// Shared constants, widths and request types for the bigram count table.
// No dependencies; imported by every module of the block.
package bct_pkg;

	// Table geometry
	localparam int TOKEN_COUNT = 27;
	localparam int COUNT_WIDTH = 20;
	localparam int DEPTH       = TOKEN_COUNT * TOKEN_COUNT;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int ROW_W       = $clog2(TOKEN_COUNT);

	// Fixed field widths
	localparam int TOK_W     = 5;
	localparam int SYM_W     = 8;
	localparam int CNT_OUT_W = 20;
	localparam int TOT_W     = 25;
	localparam int PROB_W    = 17;
	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = $clog2(FRAC_BITS + 1);
	localparam int STAT_W    = 2;

	localparam logic [COUNT_WIDTH-1:0] PAIR_MAX = '1;
	localparam logic [TOT_W-1:0]       TOT_MAX  = '1;
	localparam logic [PROB_W-1:0]      Q_ONE    = PROB_W'(1) << FRAC_BITS;

	// Symbol decode
	localparam logic [SYM_W-1:0] LETTER_FIRST = 8'd97;  // 'a'
	localparam logic [SYM_W-1:0] LETTER_LAST  = 8'd122; // 'z'
	localparam logic [SYM_W-1:0] DOT_CHAR     = 8'h2E;  // '.'
	localparam logic [TOK_W-1:0] DELIM_TOKEN  = 5'd26;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_PAIR    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FIRST   = 2'd1;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
	localparam logic [STAT_W-1:0] ST_READ    = 2'd3;

	// Request from the controller to the count store
	typedef struct packed {
		logic                   rd;
		logic                   wr;
		logic [ADDR_W-1:0]      addr;
		logic [COUNT_WIDTH-1:0] wdata;
		logic                   tot_wr;
		logic [ROW_W-1:0]       row;
		logic [TOT_W-1:0]       tot_wdata;
	} store_req_t;

endpackage

// ===== rtl/bct_store.sv =====
// Pair count memory (single port, registered read) and row total registers.
// Depends on bct_pkg.
module bct_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bct_pkg::store_req_t               req,
	output logic [bct_pkg::COUNT_WIDTH-1:0]   rdata,
	output logic [bct_pkg::TOT_W-1:0]         tot_rdata
);
	import bct_pkg::*;

	logic [COUNT_WIDTH-1:0] mem [DEPTH];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [TOT_W-1:0]       totals_q [TOKEN_COUNT];

	// no reset here: controller sweeps zeros after reset
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOKEN_COUNT; i++) begin
				totals_q[i] <= '0;
			end
		end else if (req.tot_wr) begin
			totals_q[req.row] <= req.tot_wdata;
		end
	end

	assign rdata     = rdata_q;
	assign tot_rdata = totals_q[req.row];

endmodule

// ===== rtl/bct_div.sv =====
// Radix-2 serial divider: floor(dividend * 2^16 / divisor), clamped to 1.0.
// One quotient bit per cycle into a shift register. Depends on bct_pkg.
module bct_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bct_pkg::COUNT_WIDTH-1:0]   dividend,
	input  logic [bct_pkg::TOT_W-1:0]         divisor,
	output logic                              done,
	output logic [bct_pkg::PROB_W-1:0]        quotient
);
	import bct_pkg::*;

	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W-1:0]  div_q;
	logic [PROB_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [TOT_W:0]    trial;
	logic [TOT_W:0]    diff;
	logic              fits;
	logic              short_cut;

	assign trial     = {rem_q, 1'b0};
	assign diff      = trial - {1'b0, div_q};
	assign fits      = trial >= {1'b0, div_q};
	// zero total, or count not below total: answer known at once
	assign short_cut = (divisor == '0) || (dividend >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (short_cut) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(FRAC_BITS);
				end
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= TOT_W'(dividend);
			if (divisor == '0) begin
				quo_q <= '0;
			end else if (dividend >= divisor) begin
				quo_q <= Q_ONE;
			end else begin
				quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= fits ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
			quo_q <= {quo_q[PROB_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/bigram_count_table.sv =====
// Top level of the character bigram count table: control sequencer, output register.
// Depends on bct_pkg, bct_store and bct_div.
//
// Channel  Dir  Width            Contents
// s_axis   in   tdata 24, user 1 one item: count a symbol or read an entry
// m_axis   out  tdata 72, user 2 one result beat per input beat
//
// Steps: an invalid symbol, the first symbol or an out-of-range read goes from accept
// straight to finish. A counted pair or an in-range read goes through accept, memory
// lookup, fetch and update, then the serial divider (answered at once when the total
// is zero or equal to the count, else 16 quotient bits, one per cycle, then the done
// flag), then finish, which loads the output register.
// Reset: after arst_n releases, a clearing sweep writes zero to all 729 pair
// counters, one per cycle, with s_axis_tready low; row totals clear at once.
// Stalls: the next beat is taken while a result waits in the output register; the
// following result holds in its finish cycle until m_axis frees.
module bigram_count_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // symbol[7:0], read_row[12:8], read_col[17:13], zero pad
	input  logic [0:0]  s_axis_tuser,  // mode[0]: 0 count, 1 read
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // pair_row[4:0], pair_col[9:5], pair_count[29:10],
	                                   // row_total[54:30], probability[71:55]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);
	import bct_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_LOOKUP = 6'b000100,
		S_FETCH  = 6'b001000,
		S_DIVIDE = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;

	// input fields
	logic [SYM_W-1:0] in_symbol;
	logic [TOK_W-1:0] in_row;
	logic [TOK_W-1:0] in_col;
	logic             in_mode;
	logic             in_accept;

	// symbol decode
	logic             is_letter;
	logic             is_dot;
	logic [TOK_W-1:0] tok;
	logic             tok_ok;
	logic             read_ok;

	// per-item registers
	logic                   prev_valid_q;
	logic [TOK_W-1:0]       prev_tok_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   is_read_q;
	logic [TOK_W-1:0]       row_q;
	logic [TOK_W-1:0]       col_q;
	logic [STAT_W-1:0]      status_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [TOT_W-1:0]       tot_q;
	logic [PROB_W-1:0]      prob_q;

	// output register
	logic                  out_valid_q;
	logic [TOK_W-1:0]      out_row_q;
	logic [TOK_W-1:0]      out_col_q;
	logic [CNT_OUT_W-1:0]  out_cnt_q;
	logic [TOT_W-1:0]      out_tot_q;
	logic [PROB_W-1:0]     out_prob_q;
	logic [STAT_W-1:0]     out_status_q;
	logic                  out_free;

	// store and divider
	store_req_t             req;
	logic [COUNT_WIDTH-1:0] store_cnt;
	logic [TOT_W-1:0]       store_tot;
	logic                   cnt_inc;
	logic [COUNT_WIDTH-1:0] new_cnt;
	logic [TOT_W-1:0]       new_tot;
	logic [COUNT_WIDTH-1:0] sel_cnt;
	logic [TOT_W-1:0]       sel_tot;
	logic                   div_start;
	logic                   div_done;
	logic [PROB_W-1:0]      div_quo;

	assign in_symbol = s_axis_tdata[7:0];
	assign in_row    = s_axis_tdata[12:8];
	assign in_col    = s_axis_tdata[17:13];
	assign in_mode   = s_axis_tuser[0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign is_letter = (in_symbol >= LETTER_FIRST) && (in_symbol <= LETTER_LAST);
	assign is_dot    = (in_symbol == DOT_CHAR);
	assign tok       = is_letter ? TOK_W'(in_symbol - LETTER_FIRST) : DELIM_TOKEN;
	assign tok_ok    = (is_letter || is_dot) && (int'(tok) < TOKEN_COUNT);
	assign read_ok   = (int'(in_row) < TOKEN_COUNT) && (int'(in_col) < TOKEN_COUNT);

	// update path: total moves only when the pair count really moves
	assign cnt_inc   = (store_cnt != PAIR_MAX);
	assign new_cnt   = cnt_inc ? store_cnt + 1'b1 : store_cnt;
	assign new_tot   = (cnt_inc && store_tot != TOT_MAX) ? store_tot + 1'b1 : store_tot;
	assign sel_cnt   = is_read_q ? store_cnt : new_cnt;
	assign sel_tot   = is_read_q ? store_tot : new_tot;
	assign div_start = (state_q == S_FETCH);

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		req           = '0;
		req.row       = ROW_W'(row_q);
		req.addr      = addr_q;
		req.tot_wdata = new_tot;
		case (state_q)
			S_CLEAR: begin
				req.wr   = 1'b1;
				req.addr = clr_addr_q;
			end
			S_LOOKUP: begin
				req.rd = 1'b1;
			end
			S_FETCH: begin
				req.wr     = !is_read_q;
				req.wdata  = new_cnt;
				req.tot_wr = !is_read_q;
			end
			default: begin
			end
		endcase
	end

	bct_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rdata     (store_cnt),
		.tot_rdata (store_tot)
	);

	bct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sel_cnt),
		.divisor  (sel_tot),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			prev_valid_q <= 1'b0;
			prev_tok_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// load wins over drain: a new result only loads when the slot is free
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (in_mode) begin
							state_q <= read_ok ? S_LOOKUP : S_FINISH;
						end else if (!tok_ok) begin
							state_q <= S_FINISH;
						end else begin
							prev_valid_q <= 1'b1;
							prev_tok_q   <= tok;
							state_q      <= prev_valid_q ? S_LOOKUP : S_FINISH;
						end
					end
				end
				S_LOOKUP: state_q <= S_FETCH;
				S_FETCH:  state_q <= S_DIVIDE;
				S_DIVIDE: begin
					if (div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					is_read_q <= in_mode;
					cnt_q     <= '0;
					tot_q     <= '0;
					prob_q    <= '0;
					if (in_mode) begin
						row_q    <= in_row;
						col_q    <= in_col;
						status_q <= ST_READ;
						addr_q   <= ADDR_W'(in_row) * ADDR_W'(TOKEN_COUNT) + ADDR_W'(in_col);
					end else if (!tok_ok) begin
						row_q    <= '0;
						col_q    <= '0;
						status_q <= ST_INVALID;
					end else if (!prev_valid_q) begin
						row_q    <= '0;
						col_q    <= tok;
						status_q <= ST_FIRST;
					end else begin
						row_q    <= prev_tok_q;
						col_q    <= tok;
						status_q <= ST_PAIR;
						addr_q   <= ADDR_W'(prev_tok_q) * ADDR_W'(TOKEN_COUNT) + ADDR_W'(tok);
					end
				end
			end
			S_FETCH: begin
				cnt_q <= sel_cnt;
				tot_q <= sel_tot;
			end
			S_DIVIDE: begin
				if (div_done) begin
					prob_q <= div_quo;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_row_q    <= row_q;
					out_col_q    <= col_q;
					out_cnt_q    <= CNT_OUT_W'(cnt_q);
					out_tot_q    <= tot_q;
					out_prob_q   <= prob_q;
					out_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_prob_q, out_tot_q, out_cnt_q, out_col_q, out_row_q};
	assign m_axis_tuser  = out_status_q;

	// divider reports only for an item that is waiting on it
	a_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVIDE))
		else $error("divider done outside divide state");

	// single port: never read and write the count memory together
	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd && req.wr))
		else $error("count memory read and write in one cycle");

	// a fraction never exceeds one
	a_prob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_prob_q <= Q_ONE))
		else $error("probability above 1.0");

	// a new result only loads once the previous beat has gone
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> out_valid_q && $stable(out_status_q))
		else $error("result overwritten while stalled");

endmodule
